/* rtl/mts_pkg.sv */
// Shared types and constants of the minimum-tracking stack.
package mts_pkg;

  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned DataW  = 32;
  localparam int unsigned EntryW = 34;

  typedef enum logic {
    ST_IDLE,
    ST_REFILL
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic refill;
  } mts_cmd_t;

  typedef struct packed {
    logic refill_needed;
  } mts_stat_t;

endpackage

/* rtl/mts_ctrl.sv */
// Controller of the minimum-tracking stack: handshakes and the top reload sequence.
module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mts_pkg::mts_stat_t stat_i,
  output mts_pkg::mts_cmd_t  cmd_o
);
  import mts_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
    accept      = in_valid_i && !in_stall_o;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          if (stat_i.refill_needed) begin
            state_d = ST_REFILL;
          end
        end
      end
      ST_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_refill_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REFILL |=> state_q == ST_IDLE)
    else $error("top reload lasted more than one cycle");

  a_no_accept_in_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REFILL |-> !accept)
    else $error("transfer accepted during top reload");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transfer produced no result");

endmodule

/* rtl/mts_datapath.sv */
// Datapath of the minimum-tracking stack: entry memory, cached top, minimum and result register.
module mts_datapath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          command_i,
  input  logic signed [31:0]  value_i,
  input  mts_pkg::mts_cmd_t   cmd_i,
  output mts_pkg::mts_stat_t  stat_o,
  output logic signed [31:0]  data_o,
  output logic signed [31:0]  minimum_o,
  output logic [1:0]          status_o
);
  import mts_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);

  logic [EntryW-1:0]        entry_mem_q [STACK_DEPTH];
  logic [EntryW-1:0]        rd_data_q;
  logic [FillW-1:0]         fill_q, fill_d;
  logic signed [EntryW-1:0] top_q, top_d;
  logic signed [DataW-1:0]  min_q, min_d;
  logic signed [DataW-1:0]  data_q, data_d;
  logic signed [DataW-1:0]  res_min_q, res_min_d;
  logic [1:0]               status_q, status_d;

  logic                     empty, full, top_below, push_below;
  logic signed [EntryW-1:0] min_ext, val_ext, enc_entry, restored, new_entry;
  logic signed [DataW-1:0]  dec_top;
  logic [FillW-1:0]         fill_m1, fill_m2;
  logic                     wr_en;

  always_comb begin
    empty      = (fill_q == '0);
    full       = (fill_q == FillW'(STACK_DEPTH));
    fill_m1    = fill_q - FillW'(1);
    fill_m2    = fill_q - FillW'(2);
    min_ext    = {{(EntryW - DataW){min_q[DataW-1]}}, min_q};
    val_ext    = {{(EntryW - DataW){value_i[DataW-1]}}, value_i};
    top_below  = top_q < min_ext;
    dec_top    = top_below ? min_q : top_q[DataW-1:0];
    push_below = !empty && (value_i < min_q);
    enc_entry  = {val_ext[EntryW-2:0], 1'b0} - min_ext;
    restored   = {min_ext[EntryW-2:0], 1'b0} - top_q;
    new_entry  = push_below ? enc_entry : val_ext;

    stat_o.refill_needed = (command_i == CMD_POP) && (fill_q >= FillW'(2));

    fill_d    = fill_q;
    top_d     = top_q;
    min_d     = min_q;
    data_d    = data_q;
    res_min_d = res_min_q;
    status_d  = status_q;
    wr_en     = 1'b0;

    if (cmd_i.load) begin
      unique case (command_i)
        CMD_PUSH: begin
          if (full) begin
            data_d    = dec_top;
            res_min_d = min_q;
            status_d  = STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            top_d     = new_entry;
            fill_d    = fill_q + FillW'(1);
            min_d     = (empty || push_below) ? value_i : min_q;
            data_d    = value_i;
            res_min_d = (empty || push_below) ? value_i : min_q;
            status_d  = STAT_OK;
          end
        end
        CMD_POP: begin
          if (empty) begin
            data_d    = '0;
            res_min_d = '0;
            status_d  = STAT_EMPTY;
          end else begin
            fill_d    = fill_m1;
            min_d     = top_below ? restored[DataW-1:0] : min_q;
            data_d    = dec_top;
            res_min_d = top_below ? restored[DataW-1:0] : min_q;
            status_d  = STAT_OK;
          end
        end
        default: begin
          data_d    = empty ? '0 : dec_top;
          res_min_d = empty ? '0 : min_q;
          status_d  = empty ? STAT_EMPTY : STAT_OK;
        end
      endcase
    end else if (cmd_i.refill) begin
      top_d = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[fill_q[AddrW-1:0]] <= new_entry;
    end
    if (cmd_i.load) begin
      rd_data_q <= entry_mem_q[fill_m2[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      min_q  <= {1'b0, {(DataW - 1){1'b1}}};
    end else begin
      fill_q <= fill_d;
      min_q  <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    data_q    <= data_d;
    res_min_q <= res_min_d;
    status_q  <= status_d;
  end

  assign data_o    = data_q;
  assign minimum_o = res_min_q;
  assign status_o  = status_q;

  a_fill_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(STACK_DEPTH))
    else $error("fill count beyond stack depth");

endmodule

/* rtl/min_tracking_stack_core.sv */
// Top level of the minimum-tracking stack.
// A bounded stack of signed 32-bit values that reports its current minimum with each
// result. Query, push, a pop on an empty stack and a pop that empties the stack finish
// on acceptance; a pop that leaves entries behind adds a reload state that stalls the
// input, as the cached top entry is reloaded from the entry memory, whose read data is
// registered. The result appears in the output register in the cycle after its
// transfer. While that result is stalled the input is stalled too, and the next transfer
// can be accepted in the cycle in which the waiting result is taken.
module min_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] data_o,
  output logic signed [31:0] minimum_o,
  output logic [1:0]         status_o
);
  import mts_pkg::*;

  mts_cmd_t  cmd;
  mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .command_i (command_i),
    .value_i   (value_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .data_o    (data_o),
    .minimum_o (minimum_o),
    .status_o  (status_o)
  );

endmodule
